// ===== hdl/cbm_pkg.sv =====
// Package for the clipped box mean filter: sizing constants, register codes,
// controller state type and the divider stage record. No dependencies.
`timescale 1ns / 1ps
package cbm_pkg;

   localparam int MAX_RADIUS = 7;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int LINES      = 2 * MAX_RADIUS + 2;

   localparam int RAD_W    = 3;
   localparam int DIM_W    = 11;
   localparam int SAMPLE_W = 16;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int SLOT_W   = $clog2(LINES);
   localparam int ADDR_W   = $clog2(LINES * MAX_WIDTH);
   localparam int WIN_W    = $clog2(2 * MAX_RADIUS + 2);
   localparam int AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNT_W    = $clog2(AREA_MAX + 1);
   localparam int MAG_W    = $clog2(AREA_MAX * (2 ** (SAMPLE_W - 1)) + AREA_MAX);
   localparam int SUM_W    = MAG_W + 1;
   localparam int QUO_W    = SAMPLE_W;
   localparam int HI_W     = MAG_W - QUO_W;
   localparam int IDX_W    = 2;

   localparam logic [IDX_W-1:0] CSR_RADIUS     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_MAP_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAP_HEIGHT = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_FLUSH,
      ST_DIV,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] rem;
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic [CNT_W-1:0] den;
   } div_stage_type;

endpackage

// ===== hdl/cbm_if.sv =====
// Channel interfaces of the clipped box mean filter: sample input, result
// output and register write. Depends on cbm_pkg.
`timescale 1ns / 1ps
interface cbm_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic signed [cbm_pkg::SAMPLE_W-1:0] sample;
   modport source (output valid, kind, sample, input ready);
   modport sink   (input valid, kind, sample, output ready);
endinterface

interface cbm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [cbm_pkg::SAMPLE_W-1:0] mean_value;
   logic [cbm_pkg::COL_W-1:0]      out_col;
   logic [cbm_pkg::ROW_W-1:0]      out_row;
   logic                           frame_last;
   modport source (output valid, mean_value, out_col, out_row, frame_last, input ready);
   modport sink   (input valid, mean_value, out_col, out_row, frame_last, output ready);
endinterface

interface cbm_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cbm_pkg::IDX_W-1:0]    index;
   logic [cbm_pkg::DIM_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cbm_line_store.sv =====
// Line store of the filter: one write port, one read port with registered data.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
module cbm_line_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cbm_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [cbm_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [cbm_pkg::ADDR_W-1:0]    rd_addr,
   output logic [cbm_pkg::SAMPLE_W-1:0]  rd_data
);
   import cbm_pkg::*;

   logic [SAMPLE_W-1:0] mem [LINES * MAX_WIDTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/cbm_div_cell.sv =====
// One cell of the restoring divider chain: settles one quotient bit and hands
// the partial remainder on. Depends on cbm_pkg.
`timescale 1ns / 1ps
module cbm_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  cbm_pkg::div_stage_type stage_in,
   output cbm_pkg::div_stage_type stage_out
);
   import cbm_pkg::*;

   div_stage_type stage_ff;
   div_stage_type stage_in_n;
   logic [CNT_W:0] trial;
   logic           take;

   always_comb begin
      trial = {stage_in.rem, stage_in.num[QUO_W-1]};
      take  = trial >= {1'b0, stage_in.den};
      stage_in_n       = stage_in;
      stage_in_n.rem   = take ? CNT_W'(trial - {1'b0, stage_in.den}) : trial[CNT_W-1:0];
      stage_in_n.num   = {stage_in.num[QUO_W-2:0], 1'b0};
      stage_in_n.quo   = {stage_in.quo[QUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_n;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ===== hdl/clipped_box_mean_filter.sv =====
// Flow: an item that frees no pixel goes through the check state and is done; one
// that frees a pixel reads its window one sample per cycle from the single line store
// port, then passes the 16 cells of the divider chain and waits for the result register.
// The block takes one item at a time: a new item is taken only when the last is done.
// Reset is synchronous and active high; it restores the registers and restarts the
// frame. The line store is not cleared; only rows of the current frame are read.
`timescale 1ns / 1ps
module clipped_box_mean_filter (
   input logic clock,
   input logic reset,
   cbm_req_if.sink   req_if,
   cbm_rsp_if.source rsp_if,
   cbm_csr_if.sink   csr_if
);
   import cbm_pkg::*;

   // Configuration registers.
   logic [RAD_W-1:0] radius_ff;
   logic [DIM_W-1:0] map_width_ff, map_height_ff;

   // Frame bookkeeping: next input position, next output position and the
   // store slot of each row, kept as counters so no modulo is needed.
   logic [COL_W-1:0]  in_col_ff, emit_col_ff;
   logic [ROW_W-1:0]  in_row_ff, emit_row_ff;
   logic [SLOT_W-1:0] in_slot_ff, emit_slot_ff;
   logic              frame_done_ff;

   state_type state_ff, state_in;

   // Window walk.
   logic [COL_W-1:0]  c0_ff, rd_col_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic [WIN_W-1:0]  col_cnt_ff, col_left_ff, row_left_ff;
   logic [CNT_W-1:0]  area_ff;
   logic              rd_vld_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic              neg_ff;
   logic [QUO_W-1:0]  q_ff;

   // Result register; it parts the result channel from the work in progress.
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_last_ff;

   logic req_ready, rd_en, launch, load_out;
   logic req_take, store_take, csr_take;

   logic [RAD_W-1:0] eff_r;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [DIM_W-1:0] col_next, row_next, nr, nc, nr_sum, nc_sum;
   logic [ROW_W-1:0] r0;
   logic [COL_W-1:0] c0;
   logic [SLOT_W-1:0] back, slot0;
   logic [WIN_W-1:0] row_cnt, col_cnt;
   logic [CNT_W-1:0] area;
   logic emit_oob, win_ready, walk_end, pix_last;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SUM_W-1:0] mag;
   logic [QUO_W-1:0] mean_q;
   div_stage_type chain [QUO_W+1];

   // Effective register values, clamped to what the block supports.
   always_comb begin
      eff_r = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      if (map_width_ff == '0) eff_w = DIM_W'(1);
      else if (map_width_ff > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
      else eff_w = map_width_ff;
      if (map_height_ff == '0) eff_h = DIM_W'(1);
      else if (map_height_ff > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
      else eff_h = map_height_ff;
   end

   assign req_take   = req_if.valid && req_ready;
   assign store_take = req_take && (req_if.kind == KIND_SAMPLE) && !frame_done_ff;
   assign csr_take   = csr_if.valid;
   assign col_next   = DIM_W'(in_col_ff) + DIM_W'(1);
   assign row_next   = DIM_W'(in_row_ff) + DIM_W'(1);
   assign wr_addr    = ADDR_W'(in_slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
   assign rd_addr    = ADDR_W'(rd_slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col_ff);

   cbm_line_store u_store (
      .clock   (clock),
      .wr_en   (store_take && (DIM_W'(in_col_ff) < eff_w) && (DIM_W'(in_row_ff) < eff_h)),
      .wr_addr (wr_addr),
      .wr_data (req_if.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window of the next output pixel, clipped to the map.
   always_comb begin
      emit_oob = (DIM_W'(emit_row_ff) >= eff_h) || (DIM_W'(emit_col_ff) >= eff_w);
      nr_sum   = DIM_W'(emit_row_ff) + DIM_W'(eff_r);
      nc_sum   = DIM_W'(emit_col_ff) + DIM_W'(eff_r);
      nr       = (nr_sum > eff_h - DIM_W'(1)) ? eff_h - DIM_W'(1) : nr_sum;
      nc       = (nc_sum > eff_w - DIM_W'(1)) ? eff_w - DIM_W'(1) : nc_sum;
      win_ready = frame_done_ff || (DIM_W'(in_row_ff) > nr) ||
                  ((DIM_W'(in_row_ff) == nr) && (DIM_W'(in_col_ff) > nc));
      r0 = (emit_row_ff > ROW_W'(eff_r)) ? emit_row_ff - ROW_W'(eff_r) : '0;
      c0 = (emit_col_ff > COL_W'(eff_r)) ? emit_col_ff - COL_W'(eff_r) : '0;
      row_cnt = WIN_W'(nr - DIM_W'(r0));
      col_cnt = WIN_W'(nc - DIM_W'(c0));
      area = CNT_W'((CNT_W'(row_cnt) + CNT_W'(1)) * (CNT_W'(col_cnt) + CNT_W'(1)));
      back = SLOT_W'(emit_row_ff - r0);
      slot0 = (emit_slot_ff >= back) ? emit_slot_ff - back :
              SLOT_W'(LINES - int'(back) + int'(emit_slot_ff));
      walk_end = (col_left_ff == '0) && (row_left_ff == '0);
      pix_last = (DIM_W'(emit_row_ff) == eff_h - DIM_W'(1)) &&
                 (DIM_W'(emit_col_ff) == eff_w - DIM_W'(1));
      mag = ((acc_ff < 0) ? SUM_W'(-acc_ff) : SUM_W'(acc_ff)) + SUM_W'(area_ff >> 1);
      mean_q = neg_ff ? QUO_W'(-q_ff) : q_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_CHECK;
         ST_CHECK: state_in = (!emit_oob && win_ready) ? ST_READ : ST_IDLE;
         ST_READ:  if (walk_end) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_DIV;
         ST_DIV:   state_in = ST_WAIT;
         ST_WAIT:  if (chain[QUO_W].valid) state_in = ST_OUT;
         ST_OUT:   if (load_out) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      launch    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_READ: rd_en = 1'b1;
         ST_DIV:  launch = 1'b1;
         ST_OUT:  load_out = !rsp_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end
   end

   // Registers and frame positions. A write to a known register, a frame end
   // or an output position beyond the map restarts every position.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RAD_W'(1);
         map_width_ff  <= DIM_W'(MAX_WIDTH);
         map_height_ff <= DIM_W'(MAX_HEIGHT);
         in_col_ff <= '0; in_row_ff <= '0; in_slot_ff <= '0;
         emit_col_ff <= '0; emit_row_ff <= '0; emit_slot_ff <= '0;
         frame_done_ff <= 1'b0;
      end else if (csr_take && (csr_if.index == CSR_RADIUS ||
                   csr_if.index == CSR_MAP_WIDTH || csr_if.index == CSR_MAP_HEIGHT)) begin
         case (csr_if.index)
            CSR_RADIUS:    radius_ff     <= csr_if.data[RAD_W-1:0];
            CSR_MAP_WIDTH: map_width_ff  <= csr_if.data;
            default:       map_height_ff <= csr_if.data;
         endcase
         in_col_ff <= '0; in_row_ff <= '0; in_slot_ff <= '0;
         emit_col_ff <= '0; emit_row_ff <= '0; emit_slot_ff <= '0;
         frame_done_ff <= 1'b0;
      end else if ((state_ff == ST_CHECK && emit_oob) || (load_out && pix_last)) begin
         in_col_ff <= '0; in_row_ff <= '0; in_slot_ff <= '0;
         emit_col_ff <= '0; emit_row_ff <= '0; emit_slot_ff <= '0;
         frame_done_ff <= 1'b0;
      end else begin
         if (store_take) begin
            if (col_next >= eff_w) begin
               in_col_ff <= '0;
               if (row_next >= eff_h) begin
                  in_row_ff     <= '0;
                  in_slot_ff    <= '0;
                  frame_done_ff <= 1'b1;
               end else begin
                  in_row_ff  <= ROW_W'(row_next);
                  in_slot_ff <= (in_slot_ff == SLOT_W'(LINES - 1)) ? '0 :
                                in_slot_ff + SLOT_W'(1);
               end
            end else begin
               in_col_ff <= COL_W'(col_next);
            end
         end
         if (load_out) begin
            if (DIM_W'(emit_col_ff) + DIM_W'(1) >= eff_w) begin
               emit_col_ff  <= '0;
               emit_row_ff  <= emit_row_ff + ROW_W'(1);
               emit_slot_ff <= (emit_slot_ff == SLOT_W'(LINES - 1)) ? '0 :
                               emit_slot_ff + SLOT_W'(1);
            end else begin
               emit_col_ff <= emit_col_ff + COL_W'(1);
            end
         end
      end
   end

   // Window walk: one store read per cycle, row by row, and the running sum
   // of the registered read data.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         c0_ff       <= c0;
         rd_col_ff   <= c0;
         rd_slot_ff  <= slot0;
         col_cnt_ff  <= col_cnt;
         col_left_ff <= col_cnt;
         row_left_ff <= row_cnt;
         area_ff     <= area;
         acc_ff      <= '0;
      end else begin
         if (rd_en) begin
            if (col_left_ff == '0) begin
               rd_col_ff   <= c0_ff;
               col_left_ff <= col_cnt_ff;
               row_left_ff <= row_left_ff - WIN_W'(1);
               rd_slot_ff  <= (rd_slot_ff == SLOT_W'(LINES - 1)) ? '0 :
                              rd_slot_ff + SLOT_W'(1);
            end else begin
               rd_col_ff   <= rd_col_ff + COL_W'(1);
               col_left_ff <= col_left_ff - WIN_W'(1);
            end
         end
         if (rd_vld_ff) begin
            acc_ff <= acc_ff + SUM_W'(signed'(rd_data));
         end
      end
      if (launch) begin
         neg_ff <= acc_ff < 0;
      end
      if (state_ff == ST_WAIT && chain[QUO_W].valid) begin
         q_ff <= chain[QUO_W].quo;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff <= rd_en;
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end
   end

   // Divider chain: the magnitude plus half the count, divided by the count.
   // The quotient fits the sample width, so the top bits seed the remainder.
   always_comb begin
      chain[0].valid = launch;
      chain[0].rem   = CNT_W'(mag[MAG_W-1:QUO_W]);
      chain[0].num   = mag[QUO_W-1:0];
      chain[0].quo   = '0;
      chain[0].den   = area_ff;
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      cbm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_mean_ff <= mean_q;
         rsp_col_ff  <= emit_col_ff;
         rsp_row_ff  <= emit_row_ff;
         rsp_last_ff <= pix_last;
      end
   end

   assign req_if.ready      = req_ready;
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.mean_value = rsp_mean_ff;
   assign rsp_if.out_col    = rsp_col_ff;
   assign rsp_if.out_row    = rsp_row_ff;
   assign rsp_if.frame_last = rsp_last_ff;

   // The final pixel of a frame leaves every position at the frame start.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (load_out && pix_last && !csr_take) |=> (emit_row_ff == '0 && emit_col_ff == '0 &&
                                  in_row_ff == '0 && !frame_done_ff))
      else $error("frame end did not restart positions");

   // A rounded mean never reaches beyond the sample range magnitude.
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      chain[QUO_W].valid |-> (chain[QUO_W].quo <= QUO_W'(2 ** (QUO_W - 1))))
      else $error("divider quotient out of range");

   // The window walk stays inside the row width.
   a_walk_inside: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (DIM_W'(rd_col_ff) < eff_w))
      else $error("window read beyond the row");

endmodule

// ===== dv/cbm_checker.sv =====
// Checker for the clipped box mean filter: watches the sample, result and
// register channels, predicts each result and compares it. Depends on cbm_pkg
// and the channel interfaces in hdl/cbm_if.sv.
`timescale 1ns / 1ps
module cbm_checker (
   input logic clock,
   input logic reset,
   cbm_req_if req_if,
   cbm_rsp_if rsp_if,
   cbm_csr_if csr_if,
   output int fail_count,
   output int pending_count
);
   import cbm_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_value;
      logic [COL_W-1:0]           out_col;
      logic [ROW_W-1:0]           out_row;
      logic                       frame_last;
   } pixel_type;

   logic signed [SAMPLE_W-1:0] height_rows [LINES][MAX_WIDTH];
   int unsigned win_radius, cols, rows;
   int unsigned next_in_col, next_in_row, next_out_col, next_out_row;
   bit frame_in;
   pixel_type mean_queue [$];

   assign pending_count = mean_queue.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic void restart_frame();
      next_in_col = 0;
      next_in_row = 0;
      next_out_col = 0;
      next_out_row = 0;
      frame_in = 0;
   endfunction

   // Runs one transaction and queues the pixel it frees, if any.
   task automatic predict_mean(input logic kind, input logic signed [SAMPLE_W-1:0] value);
      int unsigned w, h, r, nr, nc, r0, c0;
      longint sum, n, q;
      pixel_type px;
      w = (cols < 1) ? 1 : (cols > MAX_WIDTH) ? MAX_WIDTH : cols;
      h = (rows < 1) ? 1 : (rows > MAX_HEIGHT) ? MAX_HEIGHT : rows;
      r = (win_radius > MAX_RADIUS) ? MAX_RADIUS : win_radius;
      if (kind == KIND_SAMPLE && !frame_in) begin
         height_rows[next_in_row % LINES][next_in_col] = value;
         next_in_col++;
         if (next_in_col >= w) begin
            next_in_col = 0;
            next_in_row++;
            if (next_in_row >= h) begin
               next_in_row = 0;
               frame_in = 1;
            end
         end
      end
      // An output position beyond the map restarts the frame and frees nothing.
      if (next_out_row >= h || next_out_col >= w) begin
         restart_frame();
         return;
      end
      nr = (next_out_row + r > h - 1) ? h - 1 : next_out_row + r;
      nc = (next_out_col + r > w - 1) ? w - 1 : next_out_col + r;
      if (!(frame_in || next_in_row > nr || (next_in_row == nr && next_in_col > nc)))
         return;
      r0 = (next_out_row > r) ? next_out_row - r : 0;
      c0 = (next_out_col > r) ? next_out_col - r : 0;
      sum = 0;
      for (int unsigned y = r0; y <= nr; y++)
         for (int unsigned x = c0; x <= nc; x++)
            sum += height_rows[y % LINES][x];
      n = longint'(nr - r0 + 1) * longint'(nc - c0 + 1);
      if (sum >= 0) q = (sum + n / 2) / n;
      else q = -((-sum + n / 2) / n);
      px.mean_value = q[SAMPLE_W-1:0];
      px.out_col = next_out_col[COL_W-1:0];
      px.out_row = next_out_row[ROW_W-1:0];
      px.frame_last = (next_out_row == h - 1) && (next_out_col == w - 1);
      mean_queue.push_back(px);
      if (px.frame_last) begin
         restart_frame();
      end else begin
         next_out_col++;
         if (next_out_col >= w) begin
            next_out_col = 0;
            next_out_row++;
         end
      end
   endtask

   task automatic compare_pixel();
      pixel_type want;
      if (mean_queue.size() == 0) begin
         report($sformatf("unexpected pixel col %0d row %0d", rsp_if.out_col, rsp_if.out_row));
         return;
      end
      want = mean_queue.pop_front();
      if (rsp_if.mean_value !== want.mean_value)
         report($sformatf("mean %0d, expected %0d at col %0d row %0d", rsp_if.mean_value,
                          want.mean_value, want.out_col, want.out_row));
      if (rsp_if.out_col !== want.out_col)
         report($sformatf("column %0d, expected %0d", rsp_if.out_col, want.out_col));
      if (rsp_if.out_row !== want.out_row)
         report($sformatf("row %0d, expected %0d", rsp_if.out_row, want.out_row));
      if (rsp_if.frame_last !== want.frame_last)
         report($sformatf("frame_last %b, expected %b at col %0d row %0d",
                          rsp_if.frame_last, want.frame_last, want.out_col, want.out_row));
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         win_radius = 1;
         cols = MAX_WIDTH;
         rows = MAX_HEIGHT;
         restart_frame();
         mean_queue.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_RADIUS: win_radius = csr_if.data[RAD_W-1:0];
               CSR_MAP_WIDTH: cols = csr_if.data;
               CSR_MAP_HEIGHT: rows = csr_if.data;
               default: ;
            endcase
            if (csr_if.index inside {CSR_RADIUS, CSR_MAP_WIDTH, CSR_MAP_HEIGHT})
               restart_frame();
         end
         if (rsp_if.valid && rsp_if.ready) compare_pixel();
         if (req_if.valid && req_if.ready) predict_mean(req_if.kind, req_if.sample);
      end
   end
endmodule

// ===== dv/tb.sv =====
// Top of the clipped box mean filter testbench: clock, reset, stimulus and
// verdict. Depends on cbm_pkg, hdl/cbm_if.sv, the block and dv/cbm_checker.sv.
`timescale 1ns / 1ps
module tb;
   import cbm_pkg::*;

   // Index that selects no register.
   localparam logic [IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int fail_count;
   int pending_count;
   int items_sent;
   bit stall_free;

   cbm_req_if req_if ();
   cbm_rsp_if rsp_if ();
   cbm_csr_if csr_if ();

   clipped_box_mean_filter uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   cbm_checker checker_inst (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The result side draws a stall for every pixel; during the stretches where
   // stall_free is set it accepts at once.
   initial begin
      int gap;
      rsp_if.ready <= 0;
      @(posedge clock);
      forever begin
         gap = stall_free ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_if.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Sends one transaction after a random gap; the valid is only lowered when
   // a gap actually follows, so it never drops and rises within one step.
   task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = stall_free ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.kind <= kind;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Waits until every predicted pixel has come, then lets the block finish
   // any item still in flight so that a register write finds it idle.
   task automatic settle();
      req_if.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] index, input int unsigned value);
      csr_if.valid <= 1;
      csr_if.index <= index;
      csr_if.data <= value[DIM_W-1:0];
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 0;
   endtask

   task automatic set_shape(input int unsigned r, input int unsigned w, input int unsigned h);
      settle();
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_MAP_WIDTH, w);
      write_reg(CSR_MAP_HEIGHT, h);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_height(input int mode);
      case (mode)
         0: return 16'sh7fff;
         1: return -16'sh8000;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Sends one whole frame, with occasional drain items and, now and then,
   // samples after the frame is in, which the block must ignore. Emission
   // trails the input by at most the window reach, so that many drain items
   // plus a small margin bring out every pixel of the frame.
   task automatic send_frame(input int unsigned r, input int unsigned w, input int unsigned h,
                             input int mode);
      int unsigned lag;
      lag = ((r < h - 1) ? r : h - 1) * w + ((r < w - 1) ? r : w - 1) + 1;
      if (lag > w * h) lag = w * h;
      for (int i = 0; i < int'(w * h); i++) begin
         if ($urandom_range(0, 15) == 0) send_item(1'b1, SAMPLE_W'($urandom()));
         send_item(1'b0, (mode == 3) ? rand_height($urandom_range(0, 2)) : rand_height(mode));
      end
      if ($urandom_range(0, 1)) send_item(1'b0, SAMPLE_W'($urandom()));
      repeat (lag + 2) send_item(1'b1, SAMPLE_W'($urandom()));
   endtask

   initial begin
      int unsigned w, h, r;
      stall_free = 0;
      items_sent = 0;
      reset = 1;
      req_if.valid = 0;
      req_if.kind = 0;
      req_if.sample = 0;
      csr_if.valid = 0;
      csr_if.index = 0;
      csr_if.data = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: one pixel map, full-scale frames that sum to the rail,
      // a single row and column, the largest radius, and out-of-range values.
      set_shape(0, 1, 1);
      send_item(1'b0, -16'sh8000);
      send_item(1'b1, '0);
      set_shape(7, 3, 2);
      send_frame(7, 3, 2, 0);
      set_shape(7, 2, 2);
      send_frame(7, 2, 2, 1);
      set_shape(1, 5, 1);
      send_frame(1, 5, 1, 3);
      set_shape(2, 1, 3);
      send_frame(2, 1, 3, 3);
      // Zero sizes are clamped to one pixel; the index of no register is ignored.
      set_shape(3, 0, 0);
      send_item(1'b0, 16'sh1234);
      send_item(1'b1, '0);
      settle();
      write_reg(CSR_UNUSED, 11'h7ff);

      // Pressure: send with no gaps, then pause for every pixel to come back.
      stall_free = 1;
      set_shape(1, 4, 3);
      send_frame(1, 4, 3, 3);
      settle();
      stall_free = 0;

      // Random part: mostly small maps with random heights, now and then a wider
      // row, an oversized width, and random stall-free stretches.
      while (items_sent < 1000) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
         h = (w > 16) ? 1 : $urandom_range(1, 8);
         r = $urandom_range(0, 7);
         stall_free = ($urandom_range(0, 3) == 0);
         set_shape(r, w, h);
         if ($urandom_range(0, 19) == 0) begin
            // An oversized width clamps to the widest row; a short partial row
            // checks the clamped positions, and the next register write restarts.
            write_reg(CSR_RADIUS, 0);
            write_reg(CSR_MAP_WIDTH, $urandom_range(1025, 2047));
            write_reg(CSR_MAP_HEIGHT, 1);
            repeat ($urandom_range(4, 16)) send_item(1'b0, rand_height(2));
         end else begin
            send_frame(r, w, h, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 3);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule
